[hw/rtl/eur_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
package eur_pkg;

  localparam int unsigned TIMEOUT_W = 24;
  localparam int unsigned TPC_W     = 16;
  localparam int unsigned TRIG_W    = 16;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned IDX_W     = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_TIMEOUT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_TICKS_CM   = 2'd1;
  localparam logic [IDX_W-1:0] REG_TRIG_HIGH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_TRIG_GUARD = 2'd3;

  // Register values after reset
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 24'd400000;
  localparam logic [TPC_W-1:0]     TICKS_CM_RST   = 16'd928;
  localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST  = 16'd192;
  localparam logic [TRIG_W-1:0]    TRIG_GUARD_RST = 16'd16;

  // Measurement status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ECHO   = 2'd1;
  localparam logic [1:0] ST_ECHO_LONG = 2'd2;

  typedef struct packed {
    logic kind;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_cm;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [TPC_W-1:0] divisor;
  } div_ctl_t;

endpackage

[hw/rtl/eur_div.sv]
// Shift-subtract divider, one quotient bit per cycle.
module eur_div #(
  parameter int unsigned CW = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  eur_pkg::div_ctl_t          ctl,
  input  logic [CW-1:0]              dividend,
  output logic                       done,
  output logic [CW-1:0]              quotient
);

  localparam int unsigned CNT_W = $clog2(CW + 1);
  localparam int unsigned DV_W  = eur_pkg::TPC_W;

  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [DV_W-1:0]  rem_r,  rem_nxt;
  logic [DV_W-1:0]  div_r,  div_nxt;
  logic [CW-1:0]    quo_r,  quo_nxt;
  logic             done_r, done_nxt;
  logic [DV_W:0]    trial;
  logic [DV_W:0]    diff;
  logic             ge;

  assign trial = {rem_r, quo_r[CW-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      cnt_nxt = CNT_W'(CW);
      rem_nxt = '0;
      div_nxt = ctl.divisor;
      quo_nxt = dividend;
    end else if (cnt_r != '0) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem_nxt  = ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      quo_nxt  = {quo_r[CW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/ultrasonic_echo_ranger_unit.sv]
// Ultrasonic echo ranger: trigger sequencing, echo timing and distance result.
// An accepted tick request has its registered result in the following cycle.
// Throughput: one tick request per cycle while the result is taken; the tick
// on which the echo falls runs the divider, and no new request is accepted
// until its distance result has been registered.
// Reset (synchronous, rst_n low) returns to idle with default register values.
module ultrasonic_echo_ranger_unit #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  eur_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output eur_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [eur_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [eur_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW > eur_pkg::DIST_W) ? CW : eur_pkg::DIST_W;
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PRE, PH_HIGH, PH_POST, PH_WAIT, PH_ECHO
  } phase_t;

  typedef enum logic {
    S_TICK, S_DIV
  } seq_t;

  // configuration registers
  logic [eur_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [eur_pkg::TPC_W-1:0]     tpc_r;
  logic [eur_pkg::TRIG_W-1:0]    trig_high_r;
  logic [eur_pkg::TRIG_W-1:0]    trig_guard_r;

  seq_t                       seq_r,   seq_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [eur_pkg::TRIG_W-1:0] pt_r,    pt_nxt;
  logic [CW-1:0]              wt_r,    wt_nxt;
  logic [CW-1:0]              et_r,    et_nxt;
  logic                       ov_r,    ov_nxt;
  logic                       dq_r,    dq_nxt;
  eur_pkg::out_t              od_r,    od_nxt;

  logic              accept;
  logic              take;
  logic              need_div;
  eur_pkg::out_t     tick_res;
  eur_pkg::div_ctl_t div_ctl;
  logic              div_done;
  logic [CW-1:0]     quo;
  logic [CMP_W-1:0]  quo_ext;

  function automatic logic past_timeout(input logic [CW-1:0] c,
                                        input logic [eur_pkg::TIMEOUT_W-1:0] lim);
    past_timeout = (c == CNT_MAX) || (CMP_W'(c) > CMP_W'(lim));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= eur_pkg::TIMEOUT_RST;
      tpc_r        <= eur_pkg::TICKS_CM_RST;
      trig_high_r  <= eur_pkg::TRIG_HIGH_RST;
      trig_guard_r <= eur_pkg::TRIG_GUARD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        eur_pkg::REG_TIMEOUT:    timeout_r    <= cfg_wdata[eur_pkg::TIMEOUT_W-1:0];
        eur_pkg::REG_TICKS_CM:   tpc_r        <= cfg_wdata[eur_pkg::TPC_W-1:0];
        eur_pkg::REG_TRIG_HIGH:  trig_high_r  <= cfg_wdata[eur_pkg::TRIG_W-1:0];
        eur_pkg::REG_TRIG_GUARD: trig_guard_r <= cfg_wdata[eur_pkg::TRIG_W-1:0];
      endcase
    end
  end

  assign take     = ov_r && out_ready;
  assign in_ready = (seq_r == S_TICK) && (!ov_r || out_ready);
  assign accept   = in_valid && in_ready;

  // One tick of the ranging sequence; zero-length trigger phases fall through.
  always_comb begin
    logic emitted;
    emitted   = 1'b0;
    need_div  = 1'b0;
    phase_nxt = phase_r;
    pt_nxt    = pt_r;
    wt_nxt    = wt_r;
    et_nxt    = et_r;
    tick_res  = '0;

    if (phase_r == PH_IDLE) begin
      if (!in_data.kind) begin
        emitted = 1'b1;
      end else begin
        phase_nxt = PH_PRE;
        pt_nxt    = '0;
        wt_nxt    = '0;
        et_nxt    = '0;
      end
    end

    if (!emitted && phase_nxt == PH_PRE) begin
      if (pt_nxt < trig_guard_r) begin
        pt_nxt            = pt_nxt + 1'b1;
        tick_res.busy_res = 1'b1;
        emitted           = 1'b1;
      end else begin
        phase_nxt = PH_HIGH;
        pt_nxt    = '0;
      end
    end

    if (!emitted && phase_nxt == PH_HIGH) begin
      if (pt_nxt < trig_high_r) begin
        pt_nxt                 = pt_nxt + 1'b1;
        tick_res.trigger_level = 1'b1;
        tick_res.busy_res      = 1'b1;
        emitted                = 1'b1;
      end else begin
        phase_nxt = PH_POST;
        pt_nxt    = '0;
      end
    end

    if (!emitted && phase_nxt == PH_POST) begin
      if (pt_nxt < trig_guard_r) begin
        pt_nxt            = pt_nxt + 1'b1;
        tick_res.busy_res = 1'b1;
        emitted           = 1'b1;
      end else begin
        phase_nxt = PH_WAIT;
        pt_nxt    = '0;
      end
    end

    if (!emitted && phase_nxt == PH_WAIT) begin
      if (!in_data.echo_level) begin
        if (wt_nxt != CNT_MAX) wt_nxt = wt_nxt + 1'b1;
        if (past_timeout(wt_nxt, timeout_r)) begin
          phase_nxt         = PH_IDLE;
          tick_res.done_res = 1'b1;
          tick_res.status   = eur_pkg::ST_NO_ECHO;
        end else begin
          tick_res.busy_res = 1'b1;
        end
        emitted = 1'b1;
      end else begin
        phase_nxt = PH_ECHO;
        et_nxt    = '0;
      end
    end

    if (!emitted && phase_nxt == PH_ECHO) begin
      if (in_data.echo_level) begin
        if (et_nxt != CNT_MAX) et_nxt = et_nxt + 1'b1;
        if (past_timeout(et_nxt, timeout_r)) begin
          phase_nxt         = PH_IDLE;
          tick_res.done_res = 1'b1;
          tick_res.status   = eur_pkg::ST_ECHO_LONG;
        end else begin
          tick_res.busy_res = 1'b1;
        end
      end else begin
        // echo fell: hand the count to the divider, result follows
        phase_nxt = PH_IDLE;
        need_div  = 1'b1;
      end
    end
  end

  assign div_ctl.start   = accept && need_div;
  assign div_ctl.divisor = (tpc_r == '0) ? eur_pkg::TPC_W'(1) : tpc_r;

  eur_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (et_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_ext = CMP_W'(quo);

  always_comb begin
    seq_nxt = seq_r;
    ov_nxt  = ov_r && !take;
    dq_nxt  = dq_r;
    od_nxt  = od_r;
    unique case (seq_r)
      S_TICK: begin
        if (accept) begin
          if (need_div) begin
            seq_nxt = S_DIV;
          end else begin
            ov_nxt = 1'b1;
            od_nxt = tick_res;
          end
        end
      end
      S_DIV: begin
        if (div_done || dq_r) begin
          // hold the quotient until the result register is free
          if (!ov_r || take) begin
            seq_nxt            = S_TICK;
            dq_nxt             = 1'b0;
            ov_nxt             = 1'b1;
            od_nxt             = '0;
            od_nxt.done_res    = 1'b1;
            od_nxt.status      = eur_pkg::ST_OK;
            od_nxt.distance_cm = (quo_ext > CMP_W'(eur_pkg::DIST_MAX)) ?
                                 eur_pkg::DIST_MAX : quo_ext[eur_pkg::DIST_W-1:0];
          end else begin
            dq_nxt = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= S_TICK;
      phase_r <= PH_IDLE;
      pt_r    <= '0;
      wt_r    <= '0;
      et_r    <= '0;
      ov_r    <= 1'b0;
      dq_r    <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      ov_r  <= ov_nxt;
      dq_r  <= dq_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        pt_r    <= pt_nxt;
        wt_r    <= wt_nxt;
        et_r    <= et_nxt;
      end
    end
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (seq_r == S_DIV))
    else $error("divider finished outside a division");

  a_idle_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_DIV) |-> (phase_r == PH_IDLE) && !in_ready)
    else $error("ranging sequence moved during a division");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && od_r.trigger_level) |-> (od_r.busy_res && !od_r.done_res))
    else $error("trigger driven outside a busy tick");

  a_err_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && od_r.status != eur_pkg::ST_OK) |-> (od_r.done_res && od_r.distance_cm == '0))
    else $error("error result carries a distance");
`endif

endmodule
